/* hw/rtl/cvd_pkg.sv */
`timescale 1ns / 1ps

package cvd_pkg;

   // Framing bytes
   localparam logic [7:0] PREAMBLE_BYTE = 8'hFE;
   localparam logic [7:0] END_BYTE      = 8'hFD;

   // Reply commands
   localparam logic [7:0] CMD_OK        = 8'hFB;
   localparam logic [7:0] CMD_NG        = 8'hFA;
   localparam logic [7:0] CMD_FREQ      = 8'h03;
   localparam logic [7:0] CMD_FREQ_SEL  = 8'h25;
   localparam logic [7:0] CMD_MODE      = 8'h26;
   localparam logic [7:0] CMD_METER     = 8'h15;
   localparam logic [7:0] SUB_METER_S   = 8'h02;

   // Reply kinds
   localparam logic [2:0] KIND_OK    = 3'd0;
   localparam logic [2:0] KIND_NG    = 3'd1;
   localparam logic [2:0] KIND_FREQ  = 3'd2;
   localparam logic [2:0] KIND_MODE  = 3'd3;
   localparam logic [2:0] KIND_METER = 3'd4;
   localparam logic [2:0] KIND_OTHER = 3'd5;

   // Register indexes
   localparam logic CSR_OWN_ADDRESS   = 1'b0;
   localparam logic CSR_RADIO_ADDRESS = 1'b1;

   localparam logic [7:0] OWN_ADDRESS_RESET   = 8'd0;
   localparam logic [7:0] RADIO_ADDRESS_RESET = 8'd164;

   // Body storage
   localparam int BODY_BYTES_DEFAULT = 16;
   localparam int KEPT_BYTES         = 9;
   localparam int KEPT_IDX_W         = 4;
   localparam logic [3:0] LAST_DIGIT = 4'd9;
   localparam logic [8:0] METER_MAX  = 9'd255;

   // Controller to datapath
   typedef struct packed {
      logic pc_clear;
      logic pc_inc;
      logic len_clear;
      logic store;
      logic latch_class;
      logic freq_step;
      logic load_out;
   } cvd_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic byte_pre;
      logic byte_end;
      logic pc_seen;
      logic len_zero;
      logic len_full;
      logic chk_accept;
      logic chk_freq;
      logic dig_last;
      logic freq_bad;
      logic out_free;
   } cvd_status_type;

endpackage

/* hw/rtl/cvd_ifs.sv */
`timescale 1ns / 1ps

// Received byte channel
interface cvd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// Classified reply channel
interface cvd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  reply_kind;
   logic [31:0] frequency_hz;
   logic [7:0]  mode_code;
   logic        data_mode;
   logic [7:0]  filter_code;
   logic [7:0]  meter_level;

   modport source (output valid, output reply_kind, output frequency_hz, output mode_code,
                   output data_mode, output filter_code, output meter_level, input ready);
   modport sink   (input valid, input reply_kind, input frequency_hz, input mode_code,
                   input data_mode, input filter_code, input meter_level, output ready);
endinterface

/* hw/rtl/cvd_dp.sv */
`timescale 1ns / 1ps

module cvd_dp #(
   parameter int BODY_BYTES = cvd_pkg::BODY_BYTES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cvd_pkg::cvd_cmd_type  cmd,
   output cvd_pkg::cvd_status_type status,
   input  logic [7:0]            rx_byte,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [7:0]            csr_wdata,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [2:0]            reply_kind,
   output logic [31:0]           frequency_hz,
   output logic [7:0]            mode_code,
   output logic                  data_mode,
   output logic [7:0]            filter_code,
   output logic [7:0]            meter_level
);
   import cvd_pkg::*;

   localparam int LenW = $clog2(BODY_BYTES + 1);

   logic [7:0]      own_ff, own_in, radio_ff, radio_in;
   logic [1:0]      pc_ff, pc_in;
   logic [LenW-1:0] len_ff, len_in;
   logic [7:0]      store_ff [KEPT_BYTES];

   // staged classification
   logic [2:0]  kind_ff;
   logic [7:0]  mode_ff, filt_ff, lvl_ff;
   logic        data_ff, freq_hi_ff;
   logic [31:0] hz_ff, hz_in;
   logic [3:0]  dig_ff;
   logic        bad_ff;

   // output register
   logic        vld_ff, vld_in;
   logic [2:0]  okind_ff;
   logic [31:0] ohz_ff;
   logic [7:0]  omode_ff, ofilt_ff, olvl_ff;
   logic        odata_ff;

   // classifier outputs
   logic        chk_accept, chk_freq, freq_hi_c, data_c;
   logic [2:0]  kind_c;
   logic [7:0]  mode_c, filt_c, lvl_c;
   logic [3:0]  hund, tens, units;
   logic [8:0]  lvl_sum;
   logic        lvl_ok;

   // digit stepper
   logic [KEPT_IDX_W-1:0] byte_idx;
   logic [7:0]            dig_byte;
   logic [3:0]            nibble;
   logic                  nib_bad;

   // config registers
   always_comb begin
      own_in   = own_ff;
      radio_in = radio_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_OWN_ADDRESS:   own_in   = csr_wdata;
            CSR_RADIO_ADDRESS: radio_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // preamble count and body length
   always_comb begin
      pc_in = pc_ff;
      if (cmd.pc_clear) pc_in = 2'd0;
      else if (cmd.pc_inc && pc_ff != 2'd3) pc_in = pc_ff + 2'd1;
      len_in = len_ff;
      if (cmd.len_clear) len_in = '0;
      else if (cmd.store) len_in = len_ff + LenW'(1);
   end

   // meter level from BCD
   assign hund    = store_ff[4][3:0];
   assign tens    = store_ff[5][7:4];
   assign units   = store_ff[5][3:0];
   assign lvl_sum = 9'(hund) * 9'd100 + 9'(tens) * 9'd10 + 9'(units);
   assign lvl_ok  = (hund <= 4'd2) && (tens <= 4'd9) && (units <= 4'd9) &&
                    (lvl_sum <= METER_MAX);

   // frame check and classification
   always_comb begin
      chk_accept = 1'b0;
      chk_freq   = 1'b0;
      freq_hi_c  = 1'b0;
      kind_c     = KIND_OTHER;
      mode_c     = '0;
      data_c     = 1'b0;
      filt_c     = '0;
      lvl_c      = '0;
      if (len_ff >= LenW'(3) && store_ff[0] == own_ff && store_ff[1] == radio_ff) begin
         case (store_ff[2])
            CMD_OK: begin
               chk_accept = 1'b1;
               kind_c     = KIND_OK;
            end
            CMD_NG: begin
               chk_accept = 1'b1;
               kind_c     = KIND_NG;
            end
            CMD_FREQ: begin
               chk_accept = len_ff >= LenW'(8);
               chk_freq   = 1'b1;
               kind_c     = KIND_FREQ;
            end
            CMD_FREQ_SEL: begin
               chk_accept = len_ff >= LenW'(9);
               chk_freq   = 1'b1;
               freq_hi_c  = 1'b1;
               kind_c     = KIND_FREQ;
            end
            CMD_MODE: begin
               chk_accept = len_ff >= LenW'(7);
               kind_c     = KIND_MODE;
               mode_c     = store_ff[4];
               data_c     = store_ff[5] != 8'd0;
               filt_c     = store_ff[6];
            end
            CMD_METER: begin
               chk_accept = len_ff >= LenW'(6) && store_ff[3] == SUB_METER_S && lvl_ok;
               kind_c     = KIND_METER;
               lvl_c      = lvl_sum[7:0];
            end
            default: begin
               chk_accept = 1'b1;
               kind_c     = KIND_OTHER;
            end
         endcase
      end
   end

   // one BCD digit per step, most significant first
   assign byte_idx = KEPT_IDX_W'(7) + KEPT_IDX_W'(freq_hi_ff) - KEPT_IDX_W'(dig_ff[3:1]);
   assign dig_byte = store_ff[byte_idx];
   assign nibble   = dig_ff[0] ? dig_byte[3:0] : dig_byte[7:4];
   assign nib_bad  = nibble > 4'd9;
   assign hz_in    = (hz_ff << 3) + (hz_ff << 1) + 32'(nibble);

   // output register handshake
   always_comb begin
      vld_in = vld_ff;
      if (cmd.load_out) vld_in = 1'b1;
      else if (rsp_ready) vld_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ff   <= OWN_ADDRESS_RESET;
         radio_ff <= RADIO_ADDRESS_RESET;
         pc_ff    <= 2'd0;
         len_ff   <= '0;
         vld_ff   <= 1'b0;
      end else begin
         own_ff   <= own_in;
         radio_ff <= radio_in;
         pc_ff    <= pc_in;
         len_ff   <= len_in;
         vld_ff   <= vld_in;
      end
   end

   // body bytes, staging and output payload
   always_ff @(posedge clock) begin
      if (cmd.store && len_ff < LenW'(KEPT_BYTES)) begin
         store_ff[len_ff[KEPT_IDX_W-1:0]] <= rx_byte;
      end
      if (cmd.latch_class) begin
         kind_ff    <= kind_c;
         mode_ff    <= mode_c;
         data_ff    <= data_c;
         filt_ff    <= filt_c;
         lvl_ff     <= lvl_c;
         freq_hi_ff <= freq_hi_c;
         hz_ff      <= '0;
         dig_ff     <= '0;
         bad_ff     <= 1'b0;
      end else if (cmd.freq_step) begin
         hz_ff  <= hz_in;
         dig_ff <= dig_ff + 4'd1;
         bad_ff <= bad_ff | nib_bad;
      end
      if (cmd.load_out) begin
         okind_ff <= kind_ff;
         ohz_ff   <= hz_ff;
         omode_ff <= mode_ff;
         odata_ff <= data_ff;
         ofilt_ff <= filt_ff;
         olvl_ff  <= lvl_ff;
      end
   end

   assign status.byte_pre   = rx_byte == PREAMBLE_BYTE;
   assign status.byte_end   = rx_byte == END_BYTE;
   assign status.pc_seen    = pc_ff != 2'd0;
   assign status.len_zero   = len_ff == '0;
   assign status.len_full   = len_ff >= LenW'(BODY_BYTES);
   assign status.chk_accept = chk_accept;
   assign status.chk_freq   = chk_freq;
   assign status.dig_last   = dig_ff == LAST_DIGIT;
   assign status.freq_bad   = bad_ff | nib_bad;
   assign status.out_free   = ~vld_ff | rsp_ready;

   assign rsp_valid    = vld_ff;
   assign reply_kind   = okind_ff;
   assign frequency_hz = ohz_ff;
   assign mode_code    = omode_ff;
   assign data_mode    = odata_ff;
   assign filter_code  = ofilt_ff;
   assign meter_level  = olvl_ff;

endmodule

/* hw/rtl/cvd_ctrl.sv */
`timescale 1ns / 1ps

module cvd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  cvd_pkg::cvd_status_type status,
   output cvd_pkg::cvd_cmd_type    cmd
);
   import cvd_pkg::*;

   typedef enum logic [4:0] {
      ST_HUNT  = 5'b00001,
      ST_BODY  = 5'b00010,
      ST_CHECK = 5'b00100,
      ST_FREQ  = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      acc;

   assign in_ready = (state_ff == ST_HUNT) || (state_ff == ST_BODY);
   assign acc      = in_valid & in_ready;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_HUNT: begin
            if (acc) begin
               if (status.byte_pre) begin
                  cmd.pc_inc = 1'b1;
                  if (status.pc_seen) begin
                     cmd.len_clear = 1'b1;
                     state_in      = ST_BODY;
                  end
               end else begin
                  cmd.pc_clear = 1'b1;
               end
            end
         end
         ST_BODY: begin
            if (acc) begin
               if (status.byte_end) begin
                  cmd.pc_clear = 1'b1;
                  state_in     = ST_CHECK;
               end else if (status.byte_pre && status.len_zero) begin
                  // extra leading preamble, skipped
               end else if (!status.len_full) begin
                  cmd.store = 1'b1;
               end else begin
                  // oversize body: drop and resynchronise
                  cmd.pc_clear  = 1'b1;
                  cmd.len_clear = 1'b1;
                  state_in      = ST_HUNT;
               end
            end
         end
         ST_CHECK: begin
            cmd.latch_class = 1'b1;
            if (!status.chk_accept) state_in = ST_HUNT;
            else if (status.chk_freq) state_in = ST_FREQ;
            else state_in = ST_EMIT;
         end
         ST_FREQ: begin
            cmd.freq_step = 1'b1;
            if (status.dig_last) state_in = status.freq_bad ? ST_HUNT : ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_HUNT;
            end
         end
         default: state_in = ST_HUNT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_HUNT;
      else state_ff <= state_in;
   end

endmodule

/* hw/rtl/civ_reply_deframer_classifier_core.sv */
`timescale 1ns / 1ps

// Reply deframer and classifier for the radio's serial control bus.
// req_if carries one received bus byte per request (valid/ready). The block
// hunts for two 0xFE preambles, collects the body up to BODY_BYTES and, on
// the 0xFD terminator, checks length, addresses and command. An accepted
// frame gives one request on rsp_if with the reply kind and its decoded
// fields (unused fields are zero); rejected or oversized frames give none.
// Body bytes are taken one per cycle. After the terminator the input is held
// off through the check state, then for a frequency reply the digit steps (one
// BCD digit per cycle through the shared multiply-by-ten accumulator), then
// the load of the output register.
// A waiting reply sits in the output register while new bytes keep flowing;
// a second reply stalls in the load cycle until the receiver takes the first.
// csr_we/csr_index/csr_wdata set own_address (index 0) and radio_address
// (index 1); write them only while the block is idle. Reset is synchronous:
// the block returns to hunting, the output empties and the addresses return
// to 0 and 164.
module civ_reply_deframer_classifier_core #(
   parameter int BODY_BYTES = cvd_pkg::BODY_BYTES_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   cvd_req_if.sink       req_if,
   cvd_rsp_if.source     rsp_if,
   input  logic          csr_we,
   input  logic          csr_index,
   input  logic [7:0]    csr_wdata
);
   import cvd_pkg::*;

   cvd_cmd_type    cmd;
   cvd_status_type status;

   cvd_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_if.valid),
      .in_ready (req_if.ready),
      .status   (status),
      .cmd      (cmd)
   );

   cvd_dp #(
      .BODY_BYTES (BODY_BYTES)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .rx_byte      (req_if.rx_byte),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp_ready    (rsp_if.ready),
      .rsp_valid    (rsp_if.valid),
      .reply_kind   (rsp_if.reply_kind),
      .frequency_hz (rsp_if.frequency_hz),
      .mode_code    (rsp_if.mode_code),
      .data_mode    (rsp_if.data_mode),
      .filter_code  (rsp_if.filter_code),
      .meter_level  (rsp_if.meter_level)
   );

endmodule

/* sim/civ_reply_deframer_classifier_core_tb.sv */
`timescale 1ns / 1ps

module civ_reply_deframer_classifier_core_tb;
   import cvd_pkg::*;

   localparam int          BODY_BYTES    = BODY_BYTES_DEFAULT;
   localparam logic [3:0]  HUNDREDS_MAX  = 4'd2;
   localparam int          PHASE_BYTES   = 225;
   localparam int          SETTLE_CYCLES = 20;
   localparam int          DRAIN_LIMIT   = 2000;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] hz;
      logic [7:0]  mode;
      logic        data_flag;
      logic [7:0]  filter;
      logic [7:0]  level;
   } reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic       csr_we;
   logic       csr_index;
   logic [7:0] csr_wdata;

   cvd_req_if req_bus ();
   cvd_rsp_if rsp_bus ();

   civ_reply_deframer_classifier_core #(.BODY_BYTES(BODY_BYTES)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Shadow of the deframer state and its address registers
   logic [7:0]  own_addr   = OWN_ADDRESS_RESET;
   logic [7:0]  radio_addr = RADIO_ADDRESS_RESET;
   logic        sync_in_frame = 1'b0;
   logic [1:0]  sync_pre_cnt  = 2'd0;
   int unsigned body_len      = 0;
   logic [7:0]  body_bytes [KEPT_BYTES];

   logic [7:0] pending_bytes [$];
   reply_type  expected_replies [$];
   logic [7:0] frame_body [$];
   int         queued_count = 0;
   int         error_count  = 0;
   bit         allow_idle   = 1'b1;

   task automatic flag_error(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Five BCD bytes, least significant pair first, wrapping at 32 bits
   function automatic bit bcd_freq(input int first, output logic [31:0] hz);
      logic [7:0] bv;
      hz = '0;
      for (int i = 4; i >= 0; i--) begin
         bv = body_bytes[(first + i) % KEPT_BYTES];
         if (bv[7:4] > LAST_DIGIT || bv[3:0] > LAST_DIGIT) return 1'b0;
         hz = hz * 32'd100 + 32'(bv[7:4]) * 32'd10 + 32'(bv[3:0]);
      end
      return 1'b1;
   endfunction

   function automatic bit meter_value(output logic [7:0] lvl);
      logic [3:0] hund;
      logic [3:0] tens;
      logic [3:0] units;
      logic [9:0] v;
      hund  = body_bytes[4][3:0];
      tens  = body_bytes[5][7:4];
      units = body_bytes[5][3:0];
      lvl   = '0;
      if (hund > HUNDREDS_MAX || tens > LAST_DIGIT || units > LAST_DIGIT) return 1'b0;
      v = 10'(hund) * 10'd100 + 10'(tens) * 10'd10 + 10'(units);
      if (v > 10'(METER_MAX)) return 1'b0;
      lvl = v[7:0];
      return 1'b1;
   endfunction

   // Checks the stored body at the terminator; 1 when a reply is due
   function automatic bit classify_body(output reply_type r);
      logic [7:0]  cmd;
      int unsigned plen;
      logic [31:0] hz;
      logic [7:0]  lvl;
      r = '0;
      if (body_len < 3 || body_bytes[0] != own_addr || body_bytes[1] != radio_addr)
         return 1'b0;
      cmd  = body_bytes[2];
      plen = body_len - 3;
      case (cmd)
         CMD_OK: r.kind = KIND_OK;
         CMD_NG: r.kind = KIND_NG;
         CMD_FREQ: begin
            if (plen < 5 || !bcd_freq(3, hz)) return 1'b0;
            r.kind = KIND_FREQ;
            r.hz   = hz;
         end
         CMD_FREQ_SEL: begin
            if (plen < 6 || !bcd_freq(4, hz)) return 1'b0;
            r.kind = KIND_FREQ;
            r.hz   = hz;
         end
         CMD_MODE: begin
            if (plen < 4) return 1'b0;
            r.kind      = KIND_MODE;
            r.mode      = body_bytes[4];
            r.data_flag = (body_bytes[5] != 8'd0);
            r.filter    = body_bytes[6];
         end
         CMD_METER: begin
            if (plen < 3 || body_bytes[3] != SUB_METER_S || !meter_value(lvl)) return 1'b0;
            r.kind  = KIND_METER;
            r.level = lvl;
         end
         default: r.kind = KIND_OTHER;
      endcase
      return 1'b1;
   endfunction

   // One received byte through the frame hunter
   function automatic bit deframe_byte(input logic [7:0] b, output reply_type r);
      r = '0;
      if (!sync_in_frame) begin
         if (b == PREAMBLE_BYTE) begin
            if (sync_pre_cnt < 2'd3) sync_pre_cnt++;
            if (sync_pre_cnt >= 2'd2) begin
               sync_in_frame = 1'b1;
               body_len      = 0;
            end
         end else begin
            sync_pre_cnt = 2'd0;
         end
         return 1'b0;
      end
      if (b == END_BYTE) begin
         sync_in_frame = 1'b0;
         sync_pre_cnt  = 2'd0;
         return classify_body(r);
      end
      // extra leading preambles are skipped
      if (b == PREAMBLE_BYTE && body_len == 0) return 1'b0;
      if (body_len < BODY_BYTES) begin
         if (body_len < KEPT_BYTES) body_bytes[body_len] = b;
         body_len++;
      end else begin
         // oversized body: drop the byte and hunt again
         sync_in_frame = 1'b0;
         sync_pre_cnt  = 2'd0;
         body_len      = 0;
      end
      return 1'b0;
   endfunction

   // Byte driver with random gaps
   int gap_left = 0;
   always @(posedge clock) begin
      reply_type  rep;
      logic [7:0] nxt;
      logic       nv;
      if (reset) begin
         req_bus.valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            if (deframe_byte(req_bus.rx_byte, rep)) expected_replies.push_back(rep);
         end
         if (!(req_bus.valid && !req_bus.ready)) begin
            nv = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_bytes.size() > 0) begin
               if (allow_idle && $urandom_range(0, 5) == 0) begin
                  gap_left = $urandom_range(0, 2);
               end else begin
                  nxt = pending_bytes.pop_front();
                  req_bus.rx_byte <= nxt;
                  nv = 1'b1;
               end
            end
            req_bus.valid <= nv;
         end
      end
   end

   // Reply monitor with random back-pressure
   int stall_left = 0;
   always @(posedge clock) begin
      reply_type got;
      reply_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.kind      = rsp_bus.reply_kind;
            got.hz        = rsp_bus.frequency_hz;
            got.mode      = rsp_bus.mode_code;
            got.data_flag = rsp_bus.data_mode;
            got.filter    = rsp_bus.filter_code;
            got.level     = rsp_bus.meter_level;
            if (expected_replies.size() == 0) begin
               flag_error($sformatf("unexpected reply, kind %0d", got.kind));
            end else begin
               want = expected_replies.pop_front();
               if (got.kind !== want.kind)
                  flag_error($sformatf("reply_kind %0d, want %0d", got.kind, want.kind));
               if (got.hz !== want.hz)
                  flag_error($sformatf("frequency_hz %0d, want %0d", got.hz, want.hz));
               if (got.mode !== want.mode)
                  flag_error($sformatf("mode_code %0h, want %0h", got.mode, want.mode));
               if (got.data_flag !== want.data_flag)
                  flag_error($sformatf("data_mode %0b, want %0b", got.data_flag,
                                       want.data_flag));
               if (got.filter !== want.filter)
                  flag_error($sformatf("filter_code %0h, want %0h", got.filter, want.filter));
               if (got.level !== want.level)
                  flag_error($sformatf("meter_level %0d, want %0d", got.level, want.level));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (allow_idle && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 2);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Stimulus builders
   task automatic push_byte(input logic [7:0] b);
      pending_bytes.push_back(b);
      queued_count++;
   endtask

   task automatic begin_body(input logic [7:0] dest, input logic [7:0] src,
                             input logic [7:0] cmd);
      frame_body.delete();
      frame_body.push_back(dest);
      frame_body.push_back(src);
      frame_body.push_back(cmd);
   endtask

   task automatic add_byte(input logic [7:0] b);
      frame_body.push_back(b);
   endtask

   task automatic send_frame(input int n_pre);
      repeat (n_pre) push_byte(PREAMBLE_BYTE);
      foreach (frame_body[i]) push_byte(frame_body[i]);
      push_byte(END_BYTE);
   endtask

   function automatic logic [7:0] data_byte();
      logic [7:0] v;
      do v = 8'($urandom); while (v == END_BYTE);
      return v;
   endfunction

   task automatic add_freq_digits();
      int         pair;
      logic [7:0] bv;
      bit         all_nines;
      all_nines = ($urandom_range(0, 15) == 0);
      repeat (5) begin
         pair = all_nines ? 99 : $urandom_range(0, 99);
         bv   = {4'(pair / 10), 4'(pair % 10)};
         if ($urandom_range(0, 24) == 0) begin
            if ($urandom_range(0, 1) == 0) bv[7:4] = 4'($urandom_range(10, 15));
            else bv[3:0] = 4'($urandom_range(10, 15));
         end
         add_byte(bv);
      end
   endtask

   task automatic queue_random_frame();
      int         sel;
      int         n_pre;
      int         n;
      logic [3:0] hund;
      logic [3:0] tens;
      logic [3:0] units;
      logic [7:0] dest;
      logic [7:0] src;
      n_pre = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 5) : 2;
      dest  = ($urandom_range(0, 11) == 0) ? 8'($urandom) : own_addr;
      src   = ($urandom_range(0, 11) == 0) ? 8'($urandom) : radio_addr;
      sel   = $urandom_range(0, 13);
      // line noise ahead of the frame now and then
      if ($urandom_range(0, 9) == 0) begin
         n = $urandom_range(1, 4);
         repeat (n) push_byte(8'($urandom));
      end
      case (sel)
         0: begin_body(dest, src, CMD_OK);
         1: begin_body(dest, src, CMD_NG);
         2, 3: begin
            begin_body(dest, src, CMD_FREQ);
            add_freq_digits();
         end
         4, 5: begin
            begin_body(dest, src, CMD_FREQ_SEL);
            add_byte(data_byte());
            add_freq_digits();
         end
         6, 7: begin
            begin_body(dest, src, CMD_MODE);
            add_byte(data_byte());
            add_byte(data_byte());
            case ($urandom_range(0, 2))
               0: add_byte(8'd0);
               1: add_byte(8'd1);
               default: add_byte(data_byte());
            endcase
            add_byte(data_byte());
         end
         8, 9: begin
            begin_body(dest, src, CMD_METER);
            add_byte(($urandom_range(0, 7) == 0) ? data_byte() : SUB_METER_S);
            hund  = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(3, 15))
                                                 : 4'($urandom_range(0, 2));
            tens  = 4'($urandom_range(0, 9));
            units = 4'($urandom_range(0, 9));
            if (hund == HUNDREDS_MAX && $urandom_range(0, 2) == 0) tens = 4'd5;
            if ($urandom_range(0, 11) == 0) tens = 4'($urandom_range(10, 15));
            if ($urandom_range(0, 11) == 0) units = 4'($urandom_range(10, 15));
            add_byte({4'($urandom), hund});
            add_byte({tens, units});
         end
         10: begin_body(dest, src, data_byte());
         11: begin
            // body too short to classify
            frame_body.delete();
            n = $urandom_range(0, 2);
            repeat (n) add_byte(data_byte());
         end
         12: begin
            // around the body bound, mostly past it
            begin_body(dest, src, data_byte());
            n = $urandom_range(12, 17);
            repeat (n) add_byte(data_byte());
         end
         default: begin
            n = $urandom_range(1, 8);
            repeat (n) push_byte(8'($urandom));
            return;
         end
      endcase
      if (sel <= 10 && $urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 4);
         repeat (n) add_byte(data_byte());
      end
      // truncated frames
      if (sel <= 10 && $urandom_range(0, 7) == 0) begin
         n = $urandom_range(1, frame_body.size());
         repeat (n) void'(frame_body.pop_back());
      end
      send_frame(n_pre);
   endtask

   task automatic write_reg(input logic idx, input logic [7:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_OWN_ADDRESS) own_addr = val;
      else radio_addr = val;
   endtask

   // Wait for all requests to go and all replies to arrive, then let the block settle
   task automatic drain();
      int waited;
      waited = 0;
      @(posedge clock);
      while (pending_bytes.size() != 0 || req_bus.valid) @(posedge clock);
      while (expected_replies.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_replies.size() != 0) begin
         flag_error($sformatf("%0d replies never arrived", expected_replies.size()));
         expected_replies.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   logic [7:0] phase_own   [7] = '{8'hE0, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00};
   logic [7:0] phase_radio [7] = '{8'h94, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00};

   initial begin
      int start;
      req_bus.valid   = 1'b0;
      req_bus.rx_byte = 8'd0;
      rsp_bus.ready   = 1'b0;
      csr_we          = 1'b0;
      csr_index       = CSR_OWN_ADDRESS;
      csr_wdata       = 8'd0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed frames on the reset addresses
      begin_body(own_addr, radio_addr, CMD_OK);
      send_frame(2);
      begin_body(own_addr, radio_addr, CMD_NG);
      send_frame(4);
      // largest BCD value wraps at 32 bits
      begin_body(own_addr, radio_addr, CMD_FREQ);
      repeat (5) add_byte(8'h99);
      send_frame(2);
      begin_body(own_addr, radio_addr, CMD_FREQ_SEL);
      add_byte(8'h00);
      repeat (5) add_byte(8'h00);
      send_frame(2);
      // bad nibble in a frequency
      begin_body(own_addr, radio_addr, CMD_FREQ);
      add_byte(8'h00); add_byte(8'hA5); add_byte(8'h14); add_byte(8'h07); add_byte(8'h00);
      send_frame(2);
      begin_body(own_addr, radio_addr, CMD_MODE);
      add_byte(8'h00); add_byte(8'hFF); add_byte(8'h80); add_byte(8'h03);
      send_frame(2);
      // meter at 255 with a stray high nibble, then 256
      begin_body(own_addr, radio_addr, CMD_METER);
      add_byte(SUB_METER_S); add_byte(8'hF2); add_byte(8'h55);
      send_frame(2);
      begin_body(own_addr, radio_addr, CMD_METER);
      add_byte(SUB_METER_S); add_byte(8'h02); add_byte(8'h56);
      send_frame(2);
      // preamble byte inside a body is data
      begin_body(own_addr, radio_addr, PREAMBLE_BYTE);
      add_byte(PREAMBLE_BYTE);
      send_frame(2);
      // short body, wrong source
      begin_body(own_addr, radio_addr, CMD_OK);
      void'(frame_body.pop_back());
      send_frame(2);
      begin_body(own_addr, 8'h55, CMD_OK);
      send_frame(2);
      // noise between preambles, terminator while hunting
      push_byte(PREAMBLE_BYTE); push_byte(8'h11); push_byte(PREAMBLE_BYTE); push_byte(END_BYTE);
      // body at the bound is kept, one past it is abandoned
      begin_body(own_addr, radio_addr, CMD_OK);
      repeat (BODY_BYTES - 3) add_byte(8'h00);
      send_frame(2);
      add_byte(8'h00);
      send_frame(2);
      drain();

      // Random phases, one address setting each; the last runs without idling
      foreach (phase_own[p]) begin
         if (p >= 4) begin
            phase_own[p]   = 8'($urandom);
            phase_radio[p] = 8'($urandom);
         end
         if (p == 6) allow_idle = 1'b0;
         write_reg(CSR_OWN_ADDRESS, phase_own[p]);
         write_reg(CSR_RADIO_ADDRESS, phase_radio[p]);
         start = queued_count;
         while (queued_count - start < PHASE_BYTES) queue_random_frame();
         drain();
      end

      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
